@@ rtl/kce_pkg.sv @@
// Shared types and constants of the keyframe curve evaluator.
package kce_pkg;

	localparam int KEY_COUNT_W = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;
	localparam int FRAC_BITS   = 16;
	localparam logic [FRAC_BITS:0] FRAC_ONE = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_COUNT   = 1'b0,
		REG_INTERP_MODE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} opcode_t;

	typedef enum logic {
		MODE_CONSTANT = 1'b0,
		MODE_LINEAR   = 1'b1
	} interp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_CLAMP,
		S_SCAN,
		S_NEXT,
		S_DIV,
		S_MUL,
		S_ADD
	} state_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [5:0]         entry_index;
		logic signed [31:0] entry_time;
		logic signed [31:0] entry_value;
		logic signed [31:0] query_time;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0]     curve_value;
		logic [5:0]             floor_key;
		logic [FRAC_BITS:0]     blend_fraction;
	} result_t;

endpackage

@@ rtl/keyframe_curve_evaluator.sv @@
// Keyframe curve evaluator: keyframe tables, floor search, serial divider and blend.
// Write beat: accepted while idle, busy stays low. Evaluate beat: the first and last key
// times are read and the query clamped, a downward floor scan finds the floor key, in linear
// mode the next key is read and, when a division is needed, the restoring divider forms the
// fraction; multiply and add follow and done pulses. One evaluate at a time.
// Reset (arst_n low, asynchronous): idle, key_count 1, linear mode; key tables keep contents.
module keyframe_curve_evaluator #(
	parameter int MAX_KEYS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  kce_pkg::cmd_t                       cmd,
	output logic                                done,
	output kce_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kce_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kce_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Address width of the key tables, and a width that holds both an address and a floor key.
	localparam int AW  = $clog2(MAX_KEYS);
	localparam int IXW = (AW > 6) ? AW : 6;

	// Configuration registers
	logic [kce_pkg::KEY_COUNT_W-1:0] key_count_q;
	kce_pkg::interp_t                mode_q;

	// Sequencer and datapath registers
	kce_pkg::state_t     state_q, state_d;
	logic [AW-1:0]       last_q;       // index of the last key in use
	logic [AW-1:0]       idx_q;        // scan position
	logic [AW-1:0]       fidx_q;       // floor key found
	logic signed [31:0]  q_q;          // query, clamped in place
	logic signed [31:0]  tf_q;
	logic signed [31:0]  vf_q;
	logic signed [31:0]  vs_q;
	logic [32:0]         den_q;
	logic [32:0]         rem_q;
	logic [kce_pkg::FRAC_BITS-1:0] quot_q;
	logic [3:0]          cnt_q;
	logic [kce_pkg::FRAC_BITS:0]   frac_q;
	logic signed [50:0]  prod_q;
	kce_pkg::result_t    result_q;
	logic                done_q;

	// Key tables: one write port, one registered read port
	logic [31:0]         time_mem  [MAX_KEYS];
	logic [31:0]         value_mem [MAX_KEYS];
	logic signed [31:0]  t_rd_q;
	logic signed [31:0]  v_rd_q;
	logic [AW-1:0]       rd_addr;

	// Combinational helpers
	logic                accept;
	logic                wr_ok;
	logic [IXW-1:0]      wr_idx_ext;
	logic [AW-1:0]       wr_addr;
	logic [31:0]         kc_ext;
	logic [AW-1:0]       last_c;
	logic                scan_hit;
	logic [AW-1:0]       next_idx;
	logic signed [32:0]  num_c;
	logic signed [32:0]  den_c;
	logic                div_ok;
	logic [33:0]         rem2_c;
	logic [33:0]         diff_c;
	logic                ge_c;
	logic [kce_pkg::FRAC_BITS-1:0] quot_c;
	logic signed [32:0]  dv_c;
	logic signed [17:0]  frac_s;
	logic signed [34:0]  sum_c;
	logic [IXW-1:0]      fidx_ext;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign done      = done_q;
	assign result    = result_q;

	// Configuration write channel: always ready; write only while idle (the block itself does not enforce it).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= kce_pkg::KEY_COUNT_W'(1);
			mode_q      <= kce_pkg::MODE_LINEAR;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == kce_pkg::REG_KEY_COUNT) begin
				key_count_q <= cfg_data[kce_pkg::KEY_COUNT_W-1:0];
			end else begin
				mode_q <= kce_pkg::interp_t'(cfg_data[0]);
			end
		end
	end

	// Write address check: slots at or above the table depth are dropped.
	assign wr_idx_ext = IXW'(cmd.entry_index);
	assign wr_addr    = wr_idx_ext[AW-1:0];
	assign wr_ok      = 32'(cmd.entry_index) < 32'(MAX_KEYS);

	// Key count clamp to 1..MAX_KEYS, held as the last index in use.
	always_comb begin
		kc_ext = 32'(key_count_q);
		if (kc_ext == 32'd0) begin
			last_c = '0;
		end else if (kc_ext > 32'(MAX_KEYS)) begin
			last_c = AW'(MAX_KEYS - 1);
		end else begin
			last_c = AW'(kc_ext - 32'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.opcode == kce_pkg::OP_WRITE && wr_ok) begin
			time_mem[wr_addr]  <= cmd.entry_time;
			value_mem[wr_addr] <= cmd.entry_value;
		end
		t_rd_q <= time_mem[rd_addr];
		v_rd_q <= value_mem[rd_addr];
	end

	// Scan goes downward from the last key; the first time not above the clamped
	// query is the floor. Index zero always ends the scan.
	assign scan_hit = (t_rd_q <= q_q) || (idx_q == '0);
	assign next_idx = (idx_q < last_q) ? idx_q + 1'b1 : idx_q;

	// Fraction operands; divide only when the next key is strictly later and the
	// quotient stays below one.
	assign num_c  = {q_q[31], q_q} - {tf_q[31], tf_q};
	assign den_c  = {t_rd_q[31], t_rd_q} - {tf_q[31], tf_q};
	assign div_ok = (den_c > 33'sd0) && !num_c[32] && (num_c < den_c);

	// One restoring divider step per cycle
	assign rem2_c = {rem_q, 1'b0};
	assign ge_c   = rem2_c >= {1'b0, den_q};
	assign diff_c = rem2_c - {1'b0, den_q};
	assign quot_c = {quot_q[kce_pkg::FRAC_BITS-2:0], ge_c};

	// Blend: floor of the product over 65536 by arithmetic shift.
	assign dv_c     = {vs_q[31], vs_q} - {vf_q[31], vf_q};
	assign frac_s   = {1'b0, frac_q};
	assign sum_c    = {{3{vf_q[31]}}, vf_q} + prod_q[50:16];
	assign fidx_ext = IXW'(fidx_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kce_pkg::S_IDLE: begin
				if (start && cmd.opcode == kce_pkg::OP_EVAL) begin
					state_d = kce_pkg::S_FIRST;
				end
			end
			kce_pkg::S_FIRST: state_d = kce_pkg::S_LAST;
			kce_pkg::S_LAST:  state_d = kce_pkg::S_CLAMP;
			kce_pkg::S_CLAMP: state_d = kce_pkg::S_SCAN;
			kce_pkg::S_SCAN: begin
				if (scan_hit) begin
					state_d = (mode_q == kce_pkg::MODE_LINEAR) ? kce_pkg::S_NEXT
						: kce_pkg::S_MUL;
				end
			end
			kce_pkg::S_NEXT: state_d = div_ok ? kce_pkg::S_DIV : kce_pkg::S_MUL;
			kce_pkg::S_DIV: begin
				if (cnt_q == '0) begin
					state_d = kce_pkg::S_MUL;
				end
			end
			kce_pkg::S_MUL: state_d = kce_pkg::S_ADD;
			kce_pkg::S_ADD: state_d = kce_pkg::S_IDLE;
			default:        state_d = kce_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: busy and table read address
	always_comb begin
		busy    = (state_q != kce_pkg::S_IDLE);
		rd_addr = '0;
		unique case (state_q)
			kce_pkg::S_FIRST: rd_addr = '0;
			kce_pkg::S_LAST:  rd_addr = last_q;
			kce_pkg::S_CLAMP: rd_addr = last_q;
			kce_pkg::S_SCAN:  rd_addr = scan_hit ? next_idx : idx_q - 1'b1;
			default:          rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kce_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == kce_pkg::S_ADD);
		end
	end

	// Datapath, advanced by the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			kce_pkg::S_IDLE: begin
				if (accept && cmd.opcode == kce_pkg::OP_EVAL) begin
					q_q    <= cmd.query_time;
					last_q <= last_c;
				end
			end
			kce_pkg::S_FIRST: begin
			end
			kce_pkg::S_LAST: begin
				// raise to the first key time
				if (t_rd_q > q_q) begin
					q_q <= t_rd_q;
				end
			end
			kce_pkg::S_CLAMP: begin
				// lower to the last key time
				if (t_rd_q < q_q) begin
					q_q <= t_rd_q;
				end
				idx_q <= last_q;
			end
			kce_pkg::S_SCAN: begin
				if (scan_hit) begin
					fidx_q <= idx_q;
					tf_q   <= t_rd_q;
					vf_q   <= v_rd_q;
					vs_q   <= v_rd_q;
					frac_q <= '0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
			kce_pkg::S_NEXT: begin
				vs_q   <= v_rd_q;
				den_q  <= den_c;
				rem_q  <= num_c;
				quot_q <= '0;
				cnt_q  <= 4'(kce_pkg::FRAC_BITS - 1);
				if (!div_ok) begin
					frac_q <= kce_pkg::FRAC_ONE;
				end
			end
			kce_pkg::S_DIV: begin
				rem_q  <= ge_c ? diff_c[32:0] : rem2_c[32:0];
				quot_q <= quot_c;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					frac_q <= {1'b0, quot_c};
				end
			end
			kce_pkg::S_MUL: begin
				prod_q <= dv_c * frac_s;
			end
			kce_pkg::S_ADD: begin
				result_q.curve_value    <= sum_c[31:0];
				result_q.floor_key      <= fidx_ext[5:0];
				result_q.blend_fraction <= frac_q;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_after_blend: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == kce_pkg::S_ADD))
		else $error("result strobe without a finished blend");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kce_pkg::S_SCAN) |-> (idx_q <= last_q))
		else $error("floor scan beyond the last key");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kce_pkg::S_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.blend_fraction <= kce_pkg::FRAC_ONE))
		else $error("blend fraction above one");

	a_const_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_q == kce_pkg::MODE_CONSTANT) |-> (result.blend_fraction == '0))
		else $error("constant mode with nonzero fraction");
`endif

endmodule

@@ dv/keyframe_curve_evaluator_tb.sv @@
// Self-checking testbench for the keyframe curve evaluator.
`timescale 1ns / 100ps

module keyframe_curve_evaluator_tb;

	localparam int     MAX_KEYS    = 64;
	localparam int     ITEM_TARGET = 1900;
	localparam int     QUIET_TAIL  = 250;
	localparam longint T_MAX       = 64'sd2147483647;
	localparam longint T_MIN       = -64'sd2147483648;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// One line of the directed table: an item (with an optional pinned result) or a register write.
	typedef struct {
		row_kind_t          kind;
		kce_pkg::cmd_t      item;
		bit                 pinned;
		kce_pkg::result_t   want;
		kce_pkg::cfg_reg_t  reg_sel;
		logic [6:0]         reg_data;
	} row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	kce_pkg::cmd_t                  cmd;
	logic                           done;
	kce_pkg::result_t               result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [kce_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [kce_pkg::CFG_DATA_W-1:0] cfg_data;

	// Pinned expectation travels beside cmd so that the monitor sees both from the same edge.
	logic             pin_en;
	kce_pkg::result_t pin_res;

	// Shadow of the block, kept by the monitor.
	logic signed [31:0] key_time  [MAX_KEYS];
	logic signed [31:0] key_value [MAX_KEYS];
	logic [6:0]         cur_key_count;
	kce_pkg::interp_t   cur_mode;
	kce_pkg::result_t   pending_results[$];

	// Key times as the stimulus last wrote them, used only to aim queries.
	logic signed [31:0] plan_time [MAX_KEYS];

	int fault_count;
	int items_sent;
	int idle_pct;

	keyframe_curve_evaluator #(.MAX_KEYS(MAX_KEYS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("keyframe_curve_evaluator regression: fail");
		$finish;
	end

	function automatic logic signed [31:0] sat32(longint x);
		if (x > T_MAX)
			return 32'sh7FFF_FFFF;
		if (x < T_MIN)
			return 32'sh8000_0000;
		return 32'(x);
	endfunction

	// Evaluate the curve at one query time against the shadow tables and registers.
	function automatic kce_pkg::result_t eval_curve(logic signed [31:0] query);
		int               n;
		int               f;
		int               s;
		longint           q;
		longint           tf;
		longint           ts;
		longint           vf;
		longint           vs;
		longint           frac;
		longint           val;
		kce_pkg::result_t r;
		n = (cur_key_count == 0) ? 1 : (cur_key_count > MAX_KEYS) ? MAX_KEYS : int'(cur_key_count);
		q = query;
		// Raise to the first key time, then lower to the last one.
		if (q < key_time[0])
			q = key_time[0];
		if (q > key_time[n-1])
			q = key_time[n-1];
		f = 0;
		for (int i = 0; i < n; i++)
			if (key_time[i] <= q)
				f = i;
		vf = key_value[f];
		if (cur_mode == kce_pkg::MODE_CONSTANT) begin
			val  = vf;
			frac = 0;
		end else begin
			s  = (f + 1 < n) ? f + 1 : n - 1;
			tf = key_time[f];
			ts = key_time[s];
			vs = key_value[s];
			if (ts > tf && q >= tf) begin
				frac = ((q - tf) <<< 16) / (ts - tf);
				if (frac > 65536)
					frac = 65536;
			end else begin
				frac = 65536;
			end
			// Arithmetic shift floors toward minus infinity.
			val = vf + (((vs - vf) * frac) >>> 16);
		end
		r.curve_value    = 32'(val);
		r.floor_key      = 6'(f);
		r.blend_fraction = 17'(frac);
		return r;
	endfunction

	task automatic note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endtask

	// Monitor: check results, track register writes and predict every accepted beat.
	always @(posedge clk) begin
		kce_pkg::result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					note_fault($sformatf("unexpected result: value %h key %0d frac %0d",
						result.curve_value, result.floor_key, result.blend_fraction));
				end else begin
					want = pending_results.pop_front();
					if (result.curve_value != want.curve_value ||
						result.floor_key != want.floor_key ||
						result.blend_fraction != want.blend_fraction)
						note_fault($sformatf({"result mismatch: expected value %h key %0d ",
							"frac %0d, got value %h key %0d frac %0d"},
							want.curve_value, want.floor_key, want.blend_fraction,
							result.curve_value, result.floor_key, result.blend_fraction));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (kce_pkg::cfg_reg_t'(cfg_index))
					kce_pkg::REG_KEY_COUNT:   cur_key_count = cfg_data[6:0];
					kce_pkg::REG_INTERP_MODE: cur_mode = kce_pkg::interp_t'(cfg_data[0]);
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (cmd.opcode == kce_pkg::OP_WRITE) begin
					key_time[cmd.entry_index]  = cmd.entry_time;
					key_value[cmd.entry_index] = cmd.entry_value;
				end else begin
					pending_results.push_back(pin_en ? pin_res : eval_curve(cmd.query_time));
				end
			end
		end
	end

	// Offer one beat, after an optional idle burst, and hold it until accepted.
	task automatic send(kce_pkg::cmd_t c, bit pinned, kce_pkg::result_t want);
		if (items_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start   <= 1'b1;
		cmd     <= c;
		pin_en  <= pinned;
		pin_res <= want;
		if (c.opcode == kce_pkg::OP_WRITE)
			plan_time[c.entry_index] = c.entry_time;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// Drop start and wait until every expected result has come back and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register, then drop valid again.
	task automatic write_reg(kce_pkg::cfg_reg_t sel, logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic row_t w_row(logic [5:0] idx, logic signed [31:0] t,
			logic signed [31:0] v);
		row_t r;
		r = '{kind: ROW_ITEM, item: '0, pinned: 1'b0, want: '0,
			reg_sel: kce_pkg::REG_KEY_COUNT, reg_data: '0};
		r.item.opcode      = kce_pkg::OP_WRITE;
		r.item.entry_index = idx;
		r.item.entry_time  = t;
		r.item.entry_value = v;
		r.item.query_time  = $urandom;
		return r;
	endfunction

	function automatic row_t e_row(logic signed [31:0] q);
		row_t r;
		r = '{kind: ROW_ITEM, item: '0, pinned: 1'b0, want: '0,
			reg_sel: kce_pkg::REG_KEY_COUNT, reg_data: '0};
		r.item.opcode      = kce_pkg::OP_EVAL;
		r.item.entry_index = $urandom;
		r.item.entry_time  = $urandom;
		r.item.entry_value = $urandom;
		r.item.query_time  = q;
		return r;
	endfunction

	function automatic row_t ep_row(logic signed [31:0] q, logic signed [31:0] v,
			logic [5:0] key, logic [16:0] frac);
		row_t r;
		r = e_row(q);
		r.pinned              = 1'b1;
		r.want.curve_value    = v;
		r.want.floor_key      = key;
		r.want.blend_fraction = frac;
		return r;
	endfunction

	function automatic row_t r_row(kce_pkg::cfg_reg_t sel, logic [6:0] data);
		row_t r;
		r = '{kind: ROW_REG, item: '0, pinned: 1'b0, want: '0, reg_sel: sel, reg_data: data};
		return r;
	endfunction

	initial begin
		row_t               directed[$];
		kce_pkg::cmd_t      c;
		int                 key_cnt;
		int                 n;
		int                 style;
		int                 evals;
		int                 pick;
		int                 k;
		longint             t;
		longint             tk;
		longint             tn;
		longint             q;
		logic               mode_bit;

		arst_n        <= 1'b0;
		start         <= 1'b0;
		cmd           <= '0;
		pin_en        <= 1'b0;
		pin_res       <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		cur_key_count = 7'd1;
		cur_mode      = kce_pkg::MODE_LINEAR;
		fault_count   = 0;
		items_sent    = 0;
		idle_pct      = 20;
		for (int i = 0; i < MAX_KEYS; i++) begin
			key_time[i]  = '0;
			key_value[i] = '0;
			plan_time[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. After reset: one key, linear mode. Pinned rows are read straight off the
		// table contents; the rest go through the predictor.
		directed.push_back(w_row(6'd0, 32'sh0001_0000, 32'sh7FFF_FFFF));
		// single key: any query clamps onto it, fraction is one
		directed.push_back(ep_row(32'sh8000_0000, 32'sh7FFF_FFFF, 6'd0, kce_pkg::FRAC_ONE));
		directed.push_back(ep_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 6'd0, kce_pkg::FRAC_ONE));
		// a count of zero acts as one key
		directed.push_back(r_row(kce_pkg::REG_KEY_COUNT, 7'd0));
		directed.push_back(ep_row(32'sh0000_0000, 32'sh7FFF_FFFF, 6'd0, kce_pkg::FRAC_ONE));
		directed.push_back(w_row(6'd1, 32'sh0003_0000, 32'sh8000_0000));
		directed.push_back(w_row(6'd2, 32'sh7FFF_FFFF, 32'sh0000_0000));
		directed.push_back(r_row(kce_pkg::REG_KEY_COUNT, 7'd3));
		// full-range blend between the largest and smallest values
		directed.push_back(e_row(32'sh0002_0000));
		// past the last key: last key held, fraction one
		directed.push_back(ep_row(32'sh7FFF_FFFF, 32'sh0000_0000, 6'd2, kce_pkg::FRAC_ONE));
		// below the first key: clamped onto it, fraction zero
		directed.push_back(ep_row(32'sh8000_0000, 32'sh7FFF_FFFF, 6'd0, 17'd0));
		directed.push_back(ep_row(32'sh0003_0000, 32'sh8000_0000, 6'd1, 17'd0));
		directed.push_back(e_row(32'sh0001_2345));
		// constant mode; upper data bits must be ignored
		directed.push_back(r_row(kce_pkg::REG_INTERP_MODE, 7'h7E));
		directed.push_back(ep_row(32'sh0002_0000, 32'sh7FFF_FFFF, 6'd0, 17'd0));
		directed.push_back(ep_row(32'sh4000_0000, 32'sh8000_0000, 6'd1, 17'd0));
		directed.push_back(r_row(kce_pkg::REG_INTERP_MODE, 7'h01));
		// unordered key times: first key now later than the second
		directed.push_back(w_row(6'd0, 32'sh0005_0000, 32'sh1234_5678));
		directed.push_back(e_row(32'sh0002_0000));
		directed.push_back(e_row(32'sh8000_0000));
		directed.push_back(w_row(6'd63, 32'sh8000_0000, 32'sh7FFF_FFFF));
		// duplicate key times
		directed.push_back(w_row(6'd2, 32'sh0003_0000, 32'sh4000_0000));
		directed.push_back(e_row(32'sh0003_0000));
		directed.push_back(r_row(kce_pkg::REG_KEY_COUNT, 7'd2));
		directed.push_back(e_row(32'sh0004_0000));

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_REG) begin
				drain();
				write_reg(directed[i].reg_sel, directed[i].reg_data);
			end else begin
				send(directed[i].item, directed[i].pinned, directed[i].want);
			end
		end

		// Random part, in phases: settle registers, load a table, then mostly evaluate.
		for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
			case (phase)
				0: key_cnt = 127;
				1: key_cnt = 0;
				2: key_cnt = 64;
				3: key_cnt = 1;
				4: key_cnt = 2;
				default: begin
					pick = $urandom_range(99);
					if (pick < 50)
						key_cnt = $urandom_range(2, 8);
					else if (pick < 75)
						key_cnt = $urandom_range(9, 64);
					else
						key_cnt = $urandom_range(0, 127);
				end
			endcase
			mode_bit = (phase < 4) ? phase[0] : 1'($urandom);
			n = (key_cnt == 0) ? 1 : (key_cnt > MAX_KEYS) ? MAX_KEYS : key_cnt;

			drain();
			write_reg(kce_pkg::REG_KEY_COUNT, 7'(key_cnt));
			write_reg(kce_pkg::REG_INTERP_MODE, {6'($urandom), mode_bit});

			case ($urandom_range(3))
				0: idle_pct = 0;
				1: idle_pct = 5;
				2: idle_pct = 30;
				default: idle_pct = 70;
			endcase

			// Load every slot in use so that no evaluate ever reads a slot never written.
			// Mostly ascending times over a wide or narrow span; sometimes scrambled.
			style = $urandom_range(9);
			t = (style < 4) ? T_MIN + $urandom_range(255) : longint'(int'($urandom));
			for (int i = 0; i < n; i++) begin
				if (style == 9)
					t = longint'(int'($urandom));
				else if (i > 0 && style < 4)
					t = sat32(t + longint'($urandom_range(1, 32'hFFFF_FFFF / n)));
				else if (i > 0 && style < 7)
					t = sat32(t + longint'($urandom_range(1, 16)));
				else if (i > 0)
					t = sat32(t + (($urandom_range(1) != 0) ? longint'($urandom_range(1, 4))
						: longint'($urandom_range(1, 32'h0FFF_FFFF))));
				c.opcode      = kce_pkg::OP_WRITE;
				c.entry_index = 6'(i);
				c.entry_time  = 32'(t);
				pick = $urandom_range(9);
				c.entry_value = (pick == 0) ? 32'sh7FFF_FFFF : (pick == 1) ? 32'sh8000_0000
					: 32'($urandom);
				c.query_time  = $urandom;
				send(c, 1'b0, '0);
			end

			evals = $urandom_range(60, 140);
			for (int j = 0; j < evals && items_sent < ITEM_TARGET; j++) begin
				pick = $urandom_range(99);
				if (pick < 3 || (pick < 8 && n < MAX_KEYS)) begin
					// Noise: rewrite a live slot, or scribble on a slot outside the active range.
					c.opcode      = kce_pkg::OP_WRITE;
					c.entry_index = (pick < 3) ? 6'($urandom_range(n - 1)) :
						6'($urandom_range(MAX_KEYS - 1, n));
					c.entry_time  = $urandom;
					c.entry_value = $urandom;
					c.query_time  = $urandom;
				end else begin
					k  = $urandom_range(n - 1);
					tk = plan_time[k];
					tn = (k < n - 1) ? plan_time[k+1] : tk;
					pick = $urandom_range(99);
					if (pick < 55)
						q = (tn > tk) ? tk + longint'($urandom_range(0, 32'(tn - tk - 1))) : tk;
					else if (pick < 67)
						q = tk;
					else if (pick < 79)
						q = sat32(tk + (($urandom_range(1) != 0) ? 1 : -1));
					else if (pick < 91)
						q = longint'(int'($urandom));
					else
						q = ($urandom_range(1) != 0) ? T_MAX : T_MIN;
					c.opcode      = kce_pkg::OP_EVAL;
					c.entry_index = $urandom;
					c.entry_time  = $urandom;
					c.entry_value = $urandom;
					c.query_time  = 32'(q);
				end
				send(c, 1'b0, '0);
			end
		end

		// Let the last evaluate finish, then allow for the longest evaluate once more.
		drain();
		repeat (100) @(posedge clk);
		if (pending_results.size() != 0)
			note_fault($sformatf("%0d expected results never arrived", pending_results.size()));
		if (fault_count == 0)
			$display("keyframe_curve_evaluator regression: pass");
		else
			$display("keyframe_curve_evaluator regression: fail");
		$finish;
	end

endmodule
